FILE: rtl/assert_macros.svh
// assertion macros used by the checker file rsh_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: ante |-> cons");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: ante |=> cons");

`endif

FILE: rtl/rsh_pkg.sv
// shared types, constants and helpers of the reduce-scatter halving scheduler
// no dependencies
package rsh_pkg;

  localparam int MaxProcs = 64;
  localparam int RankW    = 6;
  localparam int GsW      = 7;
  localparam int CountW   = 32;
  localparam int ElemW    = 38;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_MY_RANK    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GROUP_SIZE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IN_PLACE   = 2'd2;

  typedef enum logic [2:0] {
    OP_COPY_IN  = 3'd0,
    OP_SEND     = 3'd1,
    OP_RECV     = 3'd2,
    OP_REDUCE   = 3'd3,
    OP_COPY_OUT = 3'd4,
    OP_EMPTY    = 3'd5
  } op_kind_e;

  typedef enum logic [1:0] {
    AREA_WORK      = 2'd0,
    AREA_SCRATCH   = 2'd1,
    AREA_USER_RECV = 2'd2,
    AREA_USER_SEND = 2'd3
  } area_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SWRD, S_SWAC, S_SWEND, S_IN, S_PSEND, S_PRECV, S_PRED,
    S_HSETUP, S_HTEST, S_R0, S_R1, S_R2, S_R3, S_HCS, S_HCR,
    S_HSEND, S_HRECV, S_HRED, S_HNEXT, S_COUT, S_HB, S_EMPTY, S_FLUSH
  } state_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [RankW-1:0]       peer;
    logic                   peer_null;
    area_e                  area;
    logic [ElemW-1:0]       offset;
    logic [ElemW-1:0]       length;
    logic                   barrier;
  } cmd_t;

  // largest power of two not above n (n >= 1)
  function automatic logic [GsW-1:0] pof2_of(input logic [GsW-1:0] n);
    logic [GsW-1:0] p;
    p = GsW'(1);
    for (int b = 0; b < GsW; b++) begin
      if (n[b]) p = GsW'(1) << b;
    end
    return p;
  endfunction

endpackage

FILE: rtl/rsh_cmd_out.sv
// command output stage: holds one command back so the final one can be marked
// depends on rsh_pkg
module rsh_cmd_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsh_pkg::cmd_t cmd_i,
  input  logic          flush_i,
  output logic          out_valid_o,
  output rsh_pkg::cmd_t out_cmd_o,
  output logic          out_last_o
);
  import rsh_pkg::*;

  cmd_t pend_q, pend_d;
  logic pend_v_q, pend_v_d;
  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic last_q, last_d;

  always_comb begin
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    valid_d  = 1'b0;
    cmd_d    = cmd_q;
    last_d   = 1'b0;
    if (push_i) begin
      // the held word goes out once a newer one arrives
      valid_d  = pend_v_q;
      cmd_d    = pend_q;
      pend_d   = cmd_i;
      pend_v_d = 1'b1;
    end else if (flush_i) begin
      valid_d  = pend_v_q;
      cmd_d    = pend_q;
      last_d   = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    cmd_q  <= cmd_d;
  end

  assign out_valid_o = valid_q;
  assign out_cmd_o   = cmd_q;
  assign out_last_o  = last_q;

endmodule

FILE: rtl/reduce_scatter_halving_scheduler_unit.sv
// Recursive-halving reduce-scatter command scheduler. Counts are taken one per
// cycle while busy is low. The count marked last starts the schedule walk and
// busy stays high during it; the final word shows in the cycle in which busy
// falls. The sweep reads the count store one rank at a time through a read and
// an accumulate state; each halving step reads three prefix sums through the
// single read port of the prefix memory and then issues its send and receive
// words, with a reduce word after the receive when that is not empty.
// Each result word is shown for exactly one cycle on result_valid_o; the
// receiver cannot stall, and list_last_o marks the final word of a list.
// depends on rsh_pkg, rsh_cmd_out
module reduce_scatter_halving_scheduler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rsh_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [rsh_pkg::CountW-1:0]    elem_count_i,
  input  logic                          count_last_i,
  output logic                          result_valid_o,
  output logic [2:0]                    op_kind_o,
  output logic [rsh_pkg::RankW-1:0]     peer_o,
  output logic                          peer_null_o,
  output logic [1:0]                    area_o,
  output logic [rsh_pkg::ElemW-1:0]     elem_offset_o,
  output logic [rsh_pkg::ElemW-1:0]     length_o,
  output logic                          barrier_after_o,
  output logic                          list_last_o
);
  import rsh_pkg::*;

  state_e state_q, state_d;

  logic [RankW-1:0] my_rank_q;
  logic [GsW-1:0]   group_size_q;
  logic             in_place_q;

  logic [GsW-1:0]   li_q, li_d, fill_q, fill_d, j_q, j_d;
  logic [ElemW-1:0] tot_q, tot_d, tot_s_q, tot_s_d, acc_q, acc_d;
  logic [ElemW-1:0] disp_rank_q, disp_rank_d, disp_left_q, disp_left_d;
  logic [CountW-1:0] cnt_rank_q, cnt_rank_d, cnt_left_q, cnt_left_d;
  logic [RankW-1:0] mask_q, mask_d;
  logic [GsW-1:0]   send_q, send_d, recv_q, recv_d, last_q, last_d;
  logic [ElemW-1:0] ps_q, ps_d, pr_q, pr_d, pl_q, pl_d, scnt_q, scnt_d, rcnt_q, rcnt_d;

  // count store and prefix-sum memory
  logic [CountW-1:0] cnt_mem [MaxProcs];
  logic [ElemW-1:0]  pre_mem [MaxProcs+1];
  logic              cnt_we, pw_en;
  logic [RankW-1:0]  cnt_waddr;
  logic [GsW-1:0]    pw_addr, pr_addr;
  logic [ElemW-1:0]  pw_data;
  logic [CountW-1:0] cnt_rdata_q;
  logic [ElemW-1:0]  pre_rdata_q;

  logic [GsW-1:0]   gs_eff, pof2, rem, two_rem, rank7, li_next;
  logic             accept, in_pair, pair_even, upper;
  logic [RankW-1:0] newrank, newdst, dst;
  logic [ElemW-1:0] c, tot_next;

  logic cmd_push, cmd_flush;
  cmd_t cmd;
  cmd_t out_cmd;

  always_comb begin
    if (group_size_q == '0) gs_eff = GsW'(1);
    else if (group_size_q > GsW'(MaxProcs)) gs_eff = GsW'(MaxProcs);
    else gs_eff = group_size_q;
  end

  assign pof2      = pof2_of(gs_eff);
  assign rem       = gs_eff - pof2;
  assign two_rem   = {rem[GsW-2:0], 1'b0};
  assign rank7     = {1'b0, my_rank_q};
  assign in_pair   = rank7 < two_rem;
  assign pair_even = in_pair && !my_rank_q[0];
  assign newrank   = in_pair ? (my_rank_q >> 1) : RankW'(rank7 - rem);
  assign newdst    = newrank ^ mask_q;
  assign dst       = ({1'b0, newdst} < rem) ? {newdst[RankW-2:0], 1'b1}
                                            : RankW'({1'b0, newdst} + rem);
  assign upper     = (newrank & mask_q) == '0;

  assign busy      = state_q != S_IDLE;
  assign accept    = start && !busy;
  assign li_next   = (li_q < GsW'(MaxProcs)) ? li_q + GsW'(1) : li_q;
  assign tot_next  = (li_q < gs_eff) ? tot_q + ElemW'(elem_count_i) : tot_q;
  assign cnt_we    = accept && (li_q < gs_eff);
  assign cnt_waddr = li_q[RankW-1:0];
  assign c         = (j_q < fill_q) ? ElemW'(cnt_rdata_q) : '0;

  always_comb begin
    state_d     = state_q;
    li_d        = li_q;
    tot_d       = tot_q;
    tot_s_d     = tot_s_q;
    fill_d      = fill_q;
    j_d         = j_q;
    acc_d       = acc_q;
    disp_rank_d = disp_rank_q;
    disp_left_d = disp_left_q;
    cnt_rank_d  = cnt_rank_q;
    cnt_left_d  = cnt_left_q;
    mask_d      = mask_q;
    send_d      = send_q;
    recv_d      = recv_q;
    last_d      = last_q;
    ps_d        = ps_q;
    pr_d        = pr_q;
    pl_d        = pl_q;
    scnt_d      = scnt_q;
    rcnt_d      = rcnt_q;
    pw_en       = 1'b0;
    pw_addr     = '0;
    pw_data     = acc_q;
    pr_addr     = '0;
    cmd_push    = 1'b0;
    cmd_flush   = 1'b0;
    cmd         = '0;
    cmd.barrier = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          li_d  = li_next;
          tot_d = tot_next;
          if (count_last_i) begin
            fill_d  = li_next;
            tot_s_d = tot_next;
            li_d    = '0;
            tot_d   = '0;
            j_d     = '0;
            acc_d   = '0;
            if (rank7 >= gs_eff || tot_next == '0) state_d = S_EMPTY;
            else state_d = S_SWRD;
          end
        end
      end
      S_SWRD: state_d = S_SWAC;
      S_SWAC: begin
        if (j_q == rank7) begin
          disp_rank_d = acc_q;
          cnt_rank_d  = CountW'(c);
        end
        if (j_q + GsW'(1) == rank7) begin
          disp_left_d = acc_q;
          cnt_left_d  = CountW'(c);
        end
        // a merged pair starts at its even rank
        if (j_q < two_rem) begin
          pw_en   = !j_q[0];
          pw_addr = j_q >> 1;
        end else begin
          pw_en   = 1'b1;
          pw_addr = j_q - rem;
        end
        acc_d = acc_q + c;
        j_d   = j_q + GsW'(1);
        state_d = (j_q + GsW'(1) == gs_eff) ? S_SWEND : S_SWRD;
      end
      S_SWEND: begin
        pw_en   = 1'b1;
        pw_addr = pof2;
        state_d = S_IN;
      end
      S_IN: begin
        cmd_push    = 1'b1;
        cmd.kind    = OP_COPY_IN;
        cmd.area    = in_place_q ? AREA_USER_RECV : AREA_USER_SEND;
        cmd.length  = tot_s_q;
        if (pair_even) state_d = S_PSEND;
        else if (in_pair) state_d = S_PRECV;
        else state_d = S_HSETUP;
      end
      S_PSEND: begin
        cmd_push   = 1'b1;
        cmd.kind   = OP_SEND;
        cmd.peer   = my_rank_q + RankW'(1);
        cmd.area   = AREA_WORK;
        cmd.length = tot_s_q;
        state_d    = S_HB;
      end
      S_PRECV: begin
        cmd_push   = 1'b1;
        cmd.kind   = OP_RECV;
        cmd.peer   = my_rank_q - RankW'(1);
        cmd.area   = AREA_SCRATCH;
        cmd.length = tot_s_q;
        state_d    = S_PRED;
      end
      S_PRED: begin
        cmd_push   = 1'b1;
        cmd.kind   = OP_REDUCE;
        cmd.area   = AREA_SCRATCH;
        cmd.length = tot_s_q;
        state_d    = S_HSETUP;
      end
      S_HSETUP: begin
        mask_d  = RankW'(pof2 >> 1);
        send_d  = '0;
        recv_d  = '0;
        last_d  = pof2;
        state_d = S_HTEST;
      end
      S_HTEST: begin
        if (mask_q == '0) begin
          state_d = S_COUT;
        end else begin
          if (upper) send_d = recv_q + GsW'(mask_q);
          else recv_d = send_q + GsW'(mask_q);
          state_d = S_R0;
        end
      end
      S_R0: begin
        pr_addr = send_q;
        state_d = S_R1;
      end
      S_R1: begin
        ps_d    = pre_rdata_q;
        pr_addr = recv_q;
        state_d = S_R2;
      end
      S_R2: begin
        pr_d    = pre_rdata_q;
        pr_addr = last_q;
        state_d = S_R3;
      end
      S_R3: begin
        pl_d    = pre_rdata_q;
        state_d = S_HCS;
      end
      S_HCS: begin
        scnt_d  = upper ? pl_q - ps_q : pr_q - ps_q;
        state_d = S_HCR;
      end
      S_HCR: begin
        rcnt_d  = upper ? ps_q - pr_q : pl_q - pr_q;
        state_d = S_HSEND;
      end
      S_HSEND: begin
        cmd_push      = 1'b1;
        cmd.kind      = OP_SEND;
        cmd.peer      = (scnt_q != '0) ? dst : '0;
        cmd.peer_null = scnt_q == '0;
        cmd.area      = AREA_WORK;
        cmd.offset    = ps_q;
        cmd.length    = scnt_q;
        cmd.barrier   = 1'b0;
        state_d       = S_HRECV;
      end
      S_HRECV: begin
        cmd_push      = 1'b1;
        cmd.kind      = OP_RECV;
        cmd.peer      = (rcnt_q != '0) ? dst : '0;
        cmd.peer_null = rcnt_q == '0;
        cmd.area      = AREA_SCRATCH;
        cmd.offset    = pr_q;
        cmd.length    = rcnt_q;
        state_d       = (rcnt_q != '0) ? S_HRED : S_HNEXT;
      end
      S_HRED: begin
        cmd_push   = 1'b1;
        cmd.kind   = OP_REDUCE;
        cmd.area   = AREA_SCRATCH;
        cmd.offset = pr_q;
        cmd.length = rcnt_q;
        state_d    = S_HNEXT;
      end
      S_HNEXT: begin
        send_d  = recv_q;
        last_d  = recv_q + GsW'(mask_q);
        mask_d  = mask_q >> 1;
        state_d = S_HTEST;
      end
      S_COUT: begin
        if (cnt_rank_q != '0) begin
          cmd_push   = 1'b1;
          cmd.kind   = OP_COPY_OUT;
          cmd.area   = AREA_WORK;
          cmd.offset = disp_rank_q;
          cmd.length = ElemW'(cnt_rank_q);
        end
        state_d = S_HB;
      end
      S_HB: begin
        // hand-back between the low even/odd pairs
        if (in_pair && my_rank_q[0] && cnt_left_q != '0) begin
          cmd_push   = 1'b1;
          cmd.kind   = OP_SEND;
          cmd.peer   = my_rank_q - RankW'(1);
          cmd.area   = AREA_WORK;
          cmd.offset = disp_left_q;
          cmd.length = ElemW'(cnt_left_q);
        end else if (pair_even && cnt_rank_q != '0) begin
          cmd_push   = 1'b1;
          cmd.kind   = OP_RECV;
          cmd.peer   = my_rank_q + RankW'(1);
          cmd.area   = AREA_USER_RECV;
          cmd.length = ElemW'(cnt_rank_q);
        end
        state_d = S_FLUSH;
      end
      S_EMPTY: begin
        cmd_push    = 1'b1;
        cmd.kind    = OP_EMPTY;
        cmd.barrier = 1'b0;
        state_d     = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_flush = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      my_rank_q    <= '0;
      group_size_q <= GsW'(1);
      in_place_q   <= 1'b0;
      li_q         <= '0;
      tot_q        <= '0;
    end else begin
      state_q <= state_d;
      li_q    <= li_d;
      tot_q   <= tot_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MY_RANK:    my_rank_q    <= cfg_wdata_i[RankW-1:0];
          CFG_GROUP_SIZE: group_size_q <= cfg_wdata_i[GsW-1:0];
          CFG_IN_PLACE:   in_place_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tot_s_q     <= tot_s_d;
    fill_q      <= fill_d;
    j_q         <= j_d;
    acc_q       <= acc_d;
    disp_rank_q <= disp_rank_d;
    disp_left_q <= disp_left_d;
    cnt_rank_q  <= cnt_rank_d;
    cnt_left_q  <= cnt_left_d;
    mask_q      <= mask_d;
    send_q      <= send_d;
    recv_q      <= recv_d;
    last_q      <= last_d;
    ps_q        <= ps_d;
    pr_q        <= pr_d;
    pl_q        <= pl_d;
    scnt_q      <= scnt_d;
    rcnt_q      <= rcnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= elem_count_i;
    cnt_rdata_q <= cnt_mem[j_q[RankW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) pre_mem[pw_addr] <= pw_data;
    pre_rdata_q <= pre_mem[pr_addr];
  end

  rsh_cmd_out u_cmd_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .cmd_i       (cmd),
    .flush_i     (cmd_flush),
    .out_valid_o (result_valid_o),
    .out_cmd_o   (out_cmd),
    .out_last_o  (list_last_o)
  );

  assign op_kind_o       = out_cmd.kind;
  assign peer_o          = out_cmd.peer;
  assign peer_null_o     = out_cmd.peer_null;
  assign area_o          = out_cmd.area;
  assign elem_offset_o   = out_cmd.offset;
  assign length_o        = out_cmd.length;
  assign barrier_after_o = out_cmd.barrier;

endmodule

FILE: rtl/rsh_checker.sv
// port-level checks on the scheduler, bound to the top level
// depends on rsh_pkg and assert_macros.svh
`include "assert_macros.svh"

module rsh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          count_last_i,
  input logic                          result_valid_o,
  input logic [2:0]                    op_kind_o,
  input logic [rsh_pkg::RankW-1:0]     peer_o,
  input logic                          peer_null_o,
  input logic [rsh_pkg::ElemW-1:0]     length_o,
  input logic                          list_last_o
);
  import rsh_pkg::*;

  // the last count always starts a walk
  `ASSERT_NEXT(a_last_busy, clk_i, rst_ni, start && !busy && count_last_i, busy)
  // words only come out of a walk
  `ASSERT_IMPLIES(a_res_busy, clk_i, rst_ni, result_valid_o, $past(busy))
  // a finished list is never followed at once by another word
  `ASSERT_NEXT(a_last_gap, clk_i, rst_ni, result_valid_o && list_last_o, !result_valid_o)
  // a null peer only on send or receive, with no rank
  `ASSERT_IMPLIES(a_null, clk_i, rst_ni, result_valid_o && peer_null_o, (op_kind_o == OP_SEND || op_kind_o == OP_RECV) && peer_o == '0)
  // an empty list is a single word
  `ASSERT_IMPLIES(a_empty, clk_i, rst_ni, result_valid_o && op_kind_o == OP_EMPTY, list_last_o && length_o == '0)

endmodule

bind reduce_scatter_halving_scheduler_unit rsh_checker u_rsh_checker (.*);

FILE: sim/reduce_scatter_halving_scheduler_unit_tb.sv
// self-checking bench for the reduce-scatter halving scheduler: loads count lists,
// predicts each command list in a local model and checks every result word
// depends on rsh_pkg and reduce_scatter_halving_scheduler_unit
module reduce_scatter_halving_scheduler_unit_tb;
  import rsh_pkg::*;

  typedef struct {
    logic [CountW-1:0] cnt;
    logic              last;
  } count_word_t;

  typedef struct packed {
    cmd_t c;
    logic last;
  } sched_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [CountW-1:0] elem_count_i = '0;
  logic count_last_i = 1'b0;
  logic result_valid_o;
  logic [2:0] op_kind_o;
  logic [RankW-1:0] peer_o;
  logic peer_null_o;
  logic [1:0] area_o;
  logic [ElemW-1:0] elem_offset_o;
  logic [ElemW-1:0] length_o;
  logic barrier_after_o;
  logic list_last_o;

  reduce_scatter_halving_scheduler_unit i_dut (.*);

  count_word_t count_pend[$];
  sched_word_t cmd_expect[$];
  int mismatches = 0;
  int items_sent = 0;
  logic no_idle = 1'b0;

  // local model state
  logic [CountW-1:0] cnt_store [MaxProcs];
  int load_ptr = 0;
  logic [ElemW-1:0] elem_total = '0;
  int m_rank = 0;
  int m_gs = 1;
  logic m_inpl = 1'b0;
  cmd_t list_buf [32];
  int list_n;

  initial forever #6 clk_i = ~clk_i;

  task automatic add_cmd(op_kind_e k, int p, logic pn, area_e a, logic [63:0] off,
                         logic [63:0] len, logic bar);
    if (list_n < 32) begin
      list_buf[list_n] = '{k, RankW'(p), pn, a, ElemW'(off), ElemW'(len), bar};
      list_n++;
    end
  endtask

  task automatic build_schedule();
    int gs, rank, p2, rem, nr, mask, nd, dst, si, ri, li, old;
    logic [63:0] acc, dr, dl, sc, rc, c;
    logic [ElemW-1:0] mc [MaxProcs];
    logic [ElemW-1:0] mo [MaxProcs];
    gs = (m_gs == 0) ? 1 : (m_gs > MaxProcs) ? MaxProcs : m_gs;
    rank = m_rank;
    list_n = 0;
    dr = 0;
    dl = 0;
    if (rank >= gs || elem_total == 0) begin
      add_cmd(OP_EMPTY, 0, 1'b0, AREA_WORK, 0, 0, 1'b0);
    end else begin
      acc = 0;
      for (int i = 0; i < gs; i++) begin
        if (i == rank) dr = acc;
        if (i + 1 == rank) dl = acc;
        acc += cnt_store[i];
      end
      add_cmd(OP_COPY_IN, 0, 1'b0, m_inpl ? AREA_USER_RECV : AREA_USER_SEND, 0,
              elem_total, 1'b1);
      p2 = 1;
      while (p2 * 2 <= gs) p2 *= 2;
      rem = gs - p2;
      if (rank < 2 * rem && rank % 2 == 0) begin
        add_cmd(OP_SEND, rank + 1, 1'b0, AREA_WORK, 0, elem_total, 1'b1);
      end else begin
        si = 0;
        ri = 0;
        li = p2;
        if (rank < 2 * rem) begin
          add_cmd(OP_RECV, rank - 1, 1'b0, AREA_SCRATCH, 0, elem_total, 1'b1);
          add_cmd(OP_REDUCE, 0, 1'b0, AREA_SCRATCH, 0, elem_total, 1'b1);
          nr = rank / 2;
        end else begin
          nr = rank - rem;
        end
        acc = 0;
        for (int i = 0; i < p2; i++) begin
          old = (i < rem) ? i * 2 + 1 : i + rem;
          c = cnt_store[old];
          if (old < 2 * rem) c += cnt_store[old - 1];
          mc[i] = ElemW'(c);
          mo[i] = ElemW'(acc);
          acc += c;
        end
        for (mask = p2 >> 1; mask > 0; mask >>= 1) begin
          nd = nr ^ mask;
          dst = (nd < rem) ? nd * 2 + 1 : nd + rem;
          sc = 0;
          rc = 0;
          if (nr < nd) begin
            si = ri + mask;
            for (int i = si; i < li; i++) sc += mc[i];
            for (int i = ri; i < si; i++) rc += mc[i];
          end else begin
            ri = si + mask;
            for (int i = si; i < ri; i++) sc += mc[i];
            for (int i = ri; i < li; i++) rc += mc[i];
          end
          add_cmd(OP_SEND, (sc != 0) ? dst : 0, sc == 0, AREA_WORK, mo[si], sc, 1'b0);
          add_cmd(OP_RECV, (rc != 0) ? dst : 0, rc == 0, AREA_SCRATCH, mo[ri], rc, 1'b1);
          if (rc != 0) add_cmd(OP_REDUCE, 0, 1'b0, AREA_SCRATCH, mo[ri], rc, 1'b1);
          si = ri;
          li = ri + mask;
        end
        if (cnt_store[rank] != 0)
          add_cmd(OP_COPY_OUT, 0, 1'b0, AREA_WORK, dr, cnt_store[rank], 1'b1);
      end
      // hand-back between the paired ranks
      if (rank < 2 * rem) begin
        if (rank % 2 == 1) begin
          if (cnt_store[rank - 1] != 0)
            add_cmd(OP_SEND, rank - 1, 1'b0, AREA_WORK, dl, cnt_store[rank - 1], 1'b1);
        end else if (cnt_store[rank] != 0) begin
          add_cmd(OP_RECV, rank + 1, 1'b0, AREA_USER_RECV, 0, cnt_store[rank], 1'b1);
        end
      end
    end
    for (int i = 0; i < list_n; i++) cmd_expect.push_back('{list_buf[i], i == list_n - 1});
  endtask

  task automatic take_count(logic [CountW-1:0] cnt, logic last);
    int gs;
    gs = (m_gs == 0) ? 1 : (m_gs > MaxProcs) ? MaxProcs : m_gs;
    if (load_ptr < gs) begin
      cnt_store[load_ptr] = cnt;
      elem_total = elem_total + ElemW'(cnt);
    end
    if (load_ptr < MaxProcs) load_ptr++;
    if (last) begin
      for (int i = load_ptr; i < MaxProcs; i++) cnt_store[i] = '0;
      build_schedule();
      load_ptr = 0;
      elem_total = '0;
    end
  endtask

  // driver: start held until the word is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) take_count(elem_count_i, count_last_i);
      if ((!start || !busy) && count_pend.size() > 0 &&
          (no_idle || $urandom_range(99) >= 21)) begin
        elem_count_i <= count_pend[0].cnt;
        count_last_i <= count_pend[0].last;
        void'(count_pend.pop_front());
        start <= 1'b1;
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (cmd_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, op_kind %0d", op_kind_o);
      end else begin
        if (op_kind_o !== cmd_expect[0].c.kind || peer_o !== cmd_expect[0].c.peer ||
            peer_null_o !== cmd_expect[0].c.peer_null || area_o !== cmd_expect[0].c.area ||
            elem_offset_o !== cmd_expect[0].c.offset ||
            length_o !== cmd_expect[0].c.length ||
            barrier_after_o !== cmd_expect[0].c.barrier ||
            list_last_o !== cmd_expect[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp k%0d p%0d n%0b a%0d o%0d l%0d b%0b e%0b, got k%0d p%0d n%0b a%0d o%0d l%0d b%0b e%0b",
                     cmd_expect[0].c.kind, cmd_expect[0].c.peer, cmd_expect[0].c.peer_null,
                     cmd_expect[0].c.area, cmd_expect[0].c.offset, cmd_expect[0].c.length,
                     cmd_expect[0].c.barrier, cmd_expect[0].last, op_kind_o, peer_o,
                     peer_null_o, area_o, elem_offset_o, length_o, barrier_after_o,
                     list_last_o);
        end
        void'(cmd_expect.pop_front());
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (count_pend.size() != 0 || start || cmd_expect.size() != 0 || busy);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_cfg(int rank, int gs, logic inpl);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MY_RANK;
    cfg_wdata_i <= CfgDataW'(rank);
    @(posedge clk_i);
    cfg_idx_i <= CFG_GROUP_SIZE;
    cfg_wdata_i <= CfgDataW'(gs);
    @(posedge clk_i);
    cfg_idx_i <= CFG_IN_PLACE;
    cfg_wdata_i <= CfgDataW'(inpl);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_rank = rank;
    m_gs = gs;
    m_inpl = inpl;
  endtask

  function automatic logic [CountW-1:0] rand_count(int mode);
    int r;
    r = $urandom_range(9);
    if (mode == 1) return '0;
    if (mode == 2) return '1;
    if (r < 3) return '0;
    if (r < 7) return CountW'($urandom_range(40));
    if (r < 8) return '1;
    return CountW'($urandom);
  endfunction

  task automatic push_list(int len, int mode);
    for (int i = 0; i < len; i++) begin
      count_pend.push_back('{rand_count(mode), i == len - 1});
      items_sent++;
    end
  endtask

  function automatic int eff_gs(int gs);
    return (gs == 0) ? 1 : (gs > MaxProcs) ? MaxProcs : gs;
  endfunction

  initial begin
    int gs, rank, nlists, len, r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    // directed: zero total, max counts, rank outside, pairs, missing and extra counts
    write_cfg(0, 1, 1'b0);
    push_list(1, 1);
    push_list(1, 2);
    wait_drained();
    write_cfg(3, 2, 1'b1);
    push_list(2, 2);
    wait_drained();
    write_cfg(1, 3, 1'b0);
    push_list(3, 2);
    wait_drained();
    write_cfg(0, 3, 1'b1);
    push_list(3, 0);
    push_list(2, 2);
    wait_drained();
    write_cfg(2, 6, 1'b0);
    push_list(8, 0);
    wait_drained();
    write_cfg(5, 0, 1'b1);
    push_list(2, 2);
    wait_drained();
    write_cfg(63, 127, 1'b1);
    push_list(4, 2);
    wait_drained();
    // random phases
    while (items_sent < 310) begin
      r = $urandom_range(19);
      if (r == 0) gs = 64;
      else if (r == 1) gs = $urandom_range(127, 65);
      else if (r == 2) gs = 0;
      else gs = $urandom_range(16, 1);
      rank = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(eff_gs(gs) - 1);
      write_cfg(rank, gs, $urandom_range(1));
      no_idle = ($urandom_range(5) == 0);
      nlists = (eff_gs(gs) > 16) ? 1 : $urandom_range(4, 1);
      for (int l = 0; l < nlists; l++) begin
        r = $urandom_range(9);
        if (r == 0) len = $urandom_range(eff_gs(gs), 1);
        else if (r == 1) len = eff_gs(gs) + $urandom_range(3, 1);
        else len = eff_gs(gs);
        push_list(len, ($urandom_range(15) == 0) ? 1 : 0);
      end
      wait_drained();
    end
    if (mismatches == 0 && cmd_expect.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
